// File: rtl/anc_frm_pkg.sv
// ----------------------------------------------------------------------------
// anc_frm_pkg
// Shared types and constants for the ancillary-data RTP packet framer.
// ----------------------------------------------------------------------------
package anc_frm_pkg;

  // Packet format constants
  localparam logic [6:0]  PAYLOAD_TYPE      = 7'd97;
  localparam logic [10:0] LINE_UNLOCATED    = 11'h7FF;
  localparam logic [11:0] OFFSET_UNLOCATED  = 12'hFFF;
  localparam logic [1:0]  FIELD_PROGRESSIVE = 2'b00;
  localparam logic [8:0]  MASK9             = 9'h1FF;
  localparam logic [7:0]  MAX_USER_WORDS    = 8'd255;
  localparam logic [8:0]  RTP_HDR_BYTES     = 9'd20;

  // Most transactions one input item can produce (6 header words + 2)
  localparam int MAX_RESULTS = 8;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Configuration register indexes
  localparam logic [1:0] CFG_DATA_ID      = 2'd0;
  localparam logic [1:0] CFG_SEC_DATA_ID  = 2'd1;
  localparam logic [1:0] CFG_SYNC_SOURCE  = 2'd2;

  typedef struct packed {
    logic [9:0]  user_word;
    logic        is_first;
    logic [7:0]  word_count;
    logic [31:0] sequence_number;
    logic [31:0] media_timestamp;
  } in_item_t;

  typedef struct packed {
    logic [31:0] packet_word;
    logic        is_last_word;
    logic [8:0]  packet_bytes;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  data_id;
    logic [9:0]  secondary_data_id;
    logic [31:0] sync_source;
  } cfg_regs_t;

  // Framer state: acc holds 'held' pending bits left-aligned, zeros below
  typedef struct packed {
    logic [31:0] acc;
    logic [4:0]  held;
    logic [8:0]  sum;
    logic [7:0]  seen;
    logic [7:0]  count;
    logic        in_packet;
  } frm_state_t;

endpackage

// File: rtl/anc_rtp_packet_framer_core.sv
// ----------------------------------------------------------------------------
// anc_rtp_packet_framer_core
// Builds one ancillary-data RTP packet from 10-bit user words and delivers
// it as big-endian 32-bit words.
// An item waits in the input register, its words in the result buffer.
// Throughput: one item per cycle while each item yields at most one word
// and out_stall is low; an item that yields k words (k = 7 or 8 on a
// first item) occupies the buffer, and so the input, until all are taken.
// Reset (rst_n low, synchronous): framer idle, buffers empty, registers 0.
// ----------------------------------------------------------------------------
module anc_rtp_packet_framer_core
  import anc_frm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // item input
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  // packet word output
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  logic                          in_vld_r;
  in_item_t                      in_item_r;
  cfg_regs_t                     cfg_r;
  frm_state_t                    state_r;
  frm_state_t                    state_nxt;
  out_item_t [MAX_RESULTS-1:0]   res;
  logic [RES_CNT_W-1:0]          res_cnt;
  out_item_t [MAX_RESULTS-1:0]   buf_r;
  logic [RES_CNT_W-1:0]          buf_cnt_r;
  logic [RES_CNT_W-1:0]          rd_ptr_r;
  logic                          pop;
  logic                          buf_free;
  logic                          fire;
  logic                          in_accept;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DATA_ID:     cfg_r.data_id           <= cfg_data[9:0];
        CFG_SEC_DATA_ID: cfg_r.secondary_data_id <= cfg_data[9:0];
        CFG_SYNC_SOURCE: cfg_r.sync_source       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake control
  assign out_valid = (rd_ptr_r != buf_cnt_r);
  assign pop       = out_valid && !out_stall;
  assign buf_free  = !out_valid || (pop && ((rd_ptr_r + 1'b1) == buf_cnt_r));
  assign fire      = in_vld_r && buf_free;
  assign in_stall  = in_vld_r && !fire;
  assign in_accept = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_accept) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r <= in_data;
    end
  end

  // Framing logic
  anc_frm_pack u_pack (
    .state_cur (state_r),
    .cfg       (cfg_r),
    .item      (in_item_r),
    .res       (res),
    .res_cnt   (res_cnt),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // Result buffer, drained one word per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r <= '0;
      rd_ptr_r  <= '0;
    end else if (fire) begin
      buf_cnt_r <= res_cnt;
      rd_ptr_r  <= '0;
    end else if (pop) begin
      rd_ptr_r  <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      buf_r <= res;
    end
  end

  assign out_data = buf_r[rd_ptr_r[2:0]];

  // Checks
  a_res_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (res_cnt <= RES_CNT_W'(MAX_RESULTS)))
    else $error("result count exceeds buffer depth");

  a_first_header: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_item_r.is_first) |=> (buf_cnt_r >= RES_CNT_W'(6)))
    else $error("first item did not produce the header words");

  a_last_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_last_word == (out_data.packet_bytes != 9'd0)))
    else $error("byte count not paired with last word");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.in_packet |-> (state_r.held == 5'd0))
    else $error("idle framer holds pending bits");

endmodule

// File: rtl/anc_frm_pack.sv
// ----------------------------------------------------------------------------
// anc_frm_pack
// Single-pass framing logic: from the current state, configuration and one
// input item, builds the list of packet words the item produces and the
// next framer state.
// ----------------------------------------------------------------------------
module anc_frm_pack
  import anc_frm_pkg::*;
(
  input  frm_state_t                       state_cur,
  input  cfg_regs_t                        cfg,
  input  in_item_t                         item,
  output out_item_t [MAX_RESULTS-1:0]      res,
  output logic [RES_CNT_W-1:0]             res_cnt,
  output frm_state_t                       state_nxt
);

  typedef struct packed {
    logic        emit;
    logic [31:0] word;
    logic [31:0] acc;
    logic [4:0]  held;
  } push_t;

  // Append 10 bits MSB first; emit a word once 32 bits are pending
  function automatic push_t push10(logic [31:0] acc, logic [4:0] held, logic [9:0] v);
    logic [63:0] win;
    push_t       r;
    win = {acc, 32'd0} | ({v, 54'd0} >> held);
    r   = '0;
    if (held >= 5'd22) begin
      r.emit = 1'b1;
      r.word = win[63:32];
      r.acc  = win[31:0];
      r.held = held - 5'd22;
    end else begin
      r.acc  = win[63:32];
      r.held = held + 5'd10;
    end
    return r;
  endfunction

  // Payload byte count of a latched count, in units of four bytes
  function automatic logic [6:0] len_bits_of(logic [7:0] c);
    logic [11:0] t;
    t = 12'd103 + {1'b0, c, 3'd0} + {3'd0, c, 1'b0};
    return t[11:5];
  endfunction

  logic [7:0]  cnt;
  logic        parity;
  logic [9:0]  dc;
  logic [11:0] len_bits;
  logic [8:0]  plen;
  logic [8:0]  total;
  frm_state_t  st0;
  logic        active;
  logic        zero_cnt;
  logic        do_word;
  logic [8:0]  seen1;
  logic [8:0]  sum1;
  logic        done;
  logic [9:0]  cksum;
  push_t       p1;
  push_t       p2;
  logic [31:0] acc1;
  logic [4:0]  held1;
  logic        pad;
  logic [RES_CNT_W-1:0] n;

  // Count, parity-coded Data_Count and packet lengths
  always_comb begin
    cnt      = (item.word_count > MAX_USER_WORDS) ? MAX_USER_WORDS : item.word_count;
    parity   = ^cnt;
    dc       = {~parity, parity, cnt};
    // ceil((72 + 10*c) / 32) * 4
    len_bits = 12'd103 + {1'b0, cnt, 3'd0} + {3'd0, cnt, 1'b0};
    plen     = {len_bits[11:5], 2'b00};
  end

  // Starting state: header preload on a first item, else the held state
  always_comb begin
    st0 = state_cur;
    if (item.is_first) begin
      st0.acc       = {cfg.data_id, cfg.secondary_data_id, dc, 2'b00};
      st0.held      = 5'd30;
      st0.sum       = (cfg.data_id[8:0] + cfg.secondary_data_id[8:0] + dc[8:0]) & MASK9;
      st0.seen      = 8'd0;
      st0.count     = cnt;
      st0.in_packet = 1'b1;
    end
  end

  // User word, checksum and padding
  always_comb begin
    active   = item.is_first | state_cur.in_packet;
    zero_cnt = item.is_first && (cnt == 8'd0);
    do_word  = active && !zero_cnt;
    seen1    = {1'b0, st0.seen} + {8'd0, do_word};
    sum1     = st0.sum + (do_word ? item.user_word[8:0] : 9'd0);
    done     = zero_cnt || (do_word && (seen1 >= {1'b0, st0.count}));
    cksum    = {~sum1[8], sum1};
    total    = RTP_HDR_BYTES + {len_bits_of(st0.count), 2'b00};

    p1 = push10(st0.acc, st0.held, item.user_word);
    if (!do_word) begin
      p1      = '0;
      p1.acc  = st0.acc;
      p1.held = st0.held;
    end
    acc1  = p1.acc;
    held1 = p1.held;

    p2 = push10(acc1, held1, cksum);
    if (!done) begin
      p2      = '0;
      p2.acc  = acc1;
      p2.held = held1;
    end
    pad = done && (p2.held != 5'd0);
  end

  // Result list
  always_comb begin
    res = '0;
    n   = '0;
    if (item.is_first) begin
      res[0].packet_word = {2'b10, 1'b0, 1'b0, 4'd0, 1'b1, PAYLOAD_TYPE,
                            item.sequence_number[15:0]};
      res[1].packet_word = item.media_timestamp;
      res[2].packet_word = cfg.sync_source;
      res[3].packet_word = {item.sequence_number[31:16], 7'd0, plen};
      res[4].packet_word = {7'd0, 1'b1, FIELD_PROGRESSIVE, 22'd0};
      res[5].packet_word = {1'b0, LINE_UNLOCATED, OFFSET_UNLOCATED, 1'b0, 7'd0};
      n = RES_CNT_W'(6);
    end
    if (p1.emit) begin
      res[n[2:0]].packet_word = p1.word;
      n = n + 1'b1;
    end
    if (p2.emit) begin
      res[n[2:0]].packet_word = p2.word;
      if (!pad) begin
        res[n[2:0]].is_last_word = 1'b1;
        res[n[2:0]].packet_bytes = total;
      end
      n = n + 1'b1;
    end
    if (pad) begin
      res[n[2:0]].packet_word  = p2.acc;
      res[n[2:0]].is_last_word = 1'b1;
      res[n[2:0]].packet_bytes = total;
      n = n + 1'b1;
    end
    res_cnt = n;
  end

  // Next state
  always_comb begin
    state_nxt = state_cur;
    if (active) begin
      state_nxt.acc       = p2.acc;
      state_nxt.held      = p2.held;
      state_nxt.sum       = sum1;
      state_nxt.seen      = seen1[7:0];
      state_nxt.count     = st0.count;
      state_nxt.in_packet = 1'b1;
      if (done) begin
        state_nxt.acc       = '0;
        state_nxt.held      = '0;
        state_nxt.in_packet = 1'b0;
      end
    end
  end

endmodule

// File: bench/anc_rtp_packet_framer_core_tb.sv
// ----------------------------------------------------------------------------
// anc_rtp_packet_framer_core_tb
// Self-checking bench for the ancillary-data RTP packet framer. A queue-fed
// driver sends items and a monitor takes packet words. A built-in framer
// model predicts every word from each accepted item. The run has a directed
// part, then random traffic in three phases with different idle and stall
// rates. DID, SDID and SSRC are reprogrammed between the phases.
// ----------------------------------------------------------------------------
module anc_rtp_packet_framer_core_tb;
  import anc_frm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_DATA_ID;
  logic [31:0] cfg_data = '0;

  anc_rtp_packet_framer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Stimulus and scoreboard storage
  in_item_t  pending_items[$];
  out_item_t expected_words[$];
  int        error_count = 0;
  int        gap_pct = 0;
  int        stall_pct = 0;

  // Framer model: register copies and packing state
  logic [9:0]  shadow_did = '0;
  logic [9:0]  shadow_sdid = '0;
  logic [31:0] shadow_ssrc = '0;
  logic [63:0] pack_bits = '0;
  int          pack_held = 0;
  logic [8:0]  csum = '0;
  logic [7:0]  words_in = '0;
  logic [7:0]  words_total = '0;
  logic        packet_open = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic expect_word(logic [31:0] w);
    out_item_t e;
    e.packet_word  = w;
    e.is_last_word = 1'b0;
    e.packet_bytes = '0;
    expected_words.push_back(e);
  endtask

  // Append 10 bits MSB first; every full 32 bits becomes a packet word
  task automatic pack10(logic [9:0] v);
    int sh;
    pack_bits = (pack_bits << 10) | {54'd0, v};
    pack_held += 10;
    while (pack_held >= 32) begin
      sh = pack_held - 32;
      expect_word(32'(pack_bits >> sh));
      pack_held = sh;
      pack_bits &= (64'd1 << sh) - 64'd1;
    end
  endtask

  function automatic logic [9:0] coded_count(logic [7:0] c);
    logic p;
    p = ^c;
    return {~p, p, c};
  endfunction

  // Bytes from the C bit through the padding
  function automatic logic [15:0] anc_length(logic [7:0] c);
    int bits;
    bits = 72 + 10 * int'(c);
    return 16'(((bits + 31) / 32) * 4);
  endfunction

  // Checksum word, zero pad, and flag the final word with the byte total
  task automatic close_packet();
    out_item_t  e;
    logic [8:0] total;
    total = RTP_HDR_BYTES + 9'(anc_length(words_total));
    pack10({~csum[8], csum});
    if (pack_held > 0) begin
      e.packet_word  = 32'(pack_bits << (32 - pack_held));
      e.is_last_word = 1'b1;
      e.packet_bytes = total;
      expected_words.push_back(e);
    end else begin
      e = expected_words.pop_back();
      e.is_last_word = 1'b1;
      e.packet_bytes = total;
      expected_words.push_back(e);
    end
    pack_bits   = '0;
    pack_held   = 0;
    packet_open = 1'b0;
  endtask

  // Expected packet words for one accepted item
  task automatic frame_item(in_item_t it);
    logic [7:0] cnt;
    logic [9:0] dc;
    if (it.is_first) begin
      cnt         = it.word_count;
      dc          = coded_count(cnt);
      words_total = cnt;
      words_in    = '0;
      pack_bits   = '0;
      pack_held   = 0;
      expect_word({2'b10, 1'b0, 1'b0, 4'd0, 1'b1, PAYLOAD_TYPE,
                   it.sequence_number[15:0]});
      expect_word(it.media_timestamp);
      expect_word(shadow_ssrc);
      expect_word({it.sequence_number[31:16], anc_length(cnt)});
      expect_word({8'd1, FIELD_PROGRESSIVE, 22'd0});
      expect_word({1'b0, LINE_UNLOCATED, OFFSET_UNLOCATED, 8'd0});
      csum = shadow_did[8:0] + shadow_sdid[8:0] + dc[8:0];
      pack10(shadow_did);
      pack10(shadow_sdid);
      pack10(dc);
      packet_open = 1'b1;
      // zero count: whole packet on this item, user word ignored
      if (cnt == 8'd0) begin
        close_packet();
        return;
      end
    end else if (!packet_open) begin
      return;
    end
    csum = csum + it.user_word[8:0];
    pack10(it.user_word);
    words_in = words_in + 8'd1;
    if (words_in >= words_total) close_packet();
  endtask

  task automatic check_word(out_item_t got);
    out_item_t e;
    if (expected_words.size() == 0) begin
      report($sformatf("unexpected word %08h", got.packet_word));
      return;
    end
    e = expected_words.pop_front();
    if (got.packet_word !== e.packet_word)
      report($sformatf("packet_word %08h, expected %08h", got.packet_word, e.packet_word));
    if (got.is_last_word !== e.is_last_word)
      report($sformatf("is_last_word %0b, expected %0b (word %08h)",
                       got.is_last_word, e.is_last_word, e.packet_word));
    if (got.packet_bytes !== e.packet_bytes)
      report($sformatf("packet_bytes %0d, expected %0d", got.packet_bytes, e.packet_bytes));
  endtask

  // Driver: present next item once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) frame_item(in_data);
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted word against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_word(out_data);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Register write; the model copy follows at the accepting edge
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DATA_ID:     shadow_did  = val[9:0];
      CFG_SEC_DATA_ID: shadow_sdid = val[9:0];
      CFG_SYNC_SOURCE: shadow_ssrc = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] did, logic [31:0] sdid, logic [31:0] ssrc);
    write_reg(CFG_DATA_ID, did);
    write_reg(CFG_SEC_DATA_ID, sdid);
    write_reg(CFG_SYNC_SOURCE, ssrc);
  endtask

  function automatic in_item_t make_item(logic [9:0] w, logic f, logic [7:0] c,
                                         logic [31:0] s, logic [31:0] t);
    in_item_t it;
    it.user_word       = w;
    it.is_first        = f;
    it.word_count      = c;
    it.sequence_number = s;
    it.media_timestamp = t;
    return it;
  endfunction

  // First item announces cnt words; only 'sent' items go out in total
  task automatic queue_packet(int cnt, int sent);
    pending_items.push_back(make_item(10'($urandom_range(0, 1023)), 1'b1, 8'(cnt),
                                      $urandom, $urandom));
    for (int i = 1; i < sent; i++)
      pending_items.push_back(make_item(10'($urandom_range(0, 1023)), 1'b0,
                                        8'($urandom_range(0, 255)), $urandom, $urandom));
  endtask

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 8);
    if (r < 97) return $urandom_range(9, 40);
    return $urandom_range(41, 120);
  endfunction

  // Mostly complete packets, some cut short by a new start, some stray words
  task automatic queue_random_traffic(int budget);
    int n, r, cnt, sent;
    n = 0;
    while (n < budget) begin
      r = $urandom_range(0, 99);
      if (r < 82) begin
        cnt  = pick_count();
        sent = (cnt == 0) ? 1 : cnt;
      end else if (r < 92) begin
        cnt  = $urandom_range(2, 30);
        sent = $urandom_range(1, cnt - 1);
      end else begin
        cnt  = 0;
        sent = $urandom_range(1, 3);
        for (int i = 0; i < sent; i++)
          pending_items.push_back(make_item(10'($urandom_range(0, 1023)), 1'b0,
                                            8'($urandom_range(0, 255)), $urandom, $urandom));
        n += sent;
        continue;
      end
      queue_packet(cnt, sent);
      n += sent;
    end
  endtask

  // Wait until every item is taken and every word has arrived
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic queue_directed();
    // zero count, field extremes
    pending_items.push_back(make_item(10'h3FF, 1'b1, 8'd0, 32'h0000_0000, 32'h0000_0000));
    pending_items.push_back(make_item(10'h000, 1'b1, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // word while idle is dropped
    pending_items.push_back(make_item(10'h3FF, 1'b0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // single-word packets
    pending_items.push_back(make_item(10'h3FF, 1'b1, 8'd1, 32'h1234_5678, 32'h9ABC_DEF0));
    pending_items.push_back(make_item(10'h000, 1'b1, 8'd1, 32'hFFFF_0000, 32'h0000_FFFF));
    // three words, checksum carry
    pending_items.push_back(make_item(10'h200, 1'b1, 8'd3, 32'h0000_FFFF, 32'hFFFF_0000));
    pending_items.push_back(make_item(10'h1FF, 1'b0, 8'h00, 32'h0, 32'h0));
    pending_items.push_back(make_item(10'h3FF, 1'b0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // restart mid-packet, incl. a maximum count packet cut short
    queue_packet(2, 1);
    queue_packet(255, 4);
    queue_packet(4, 4);
    queue_packet(5, 5);
    pending_items.push_back(make_item(10'h155, 1'b0, 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA));
  endtask

  // Main sequence
  initial begin
    gap_pct   = 8;
    stall_pct = 66;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_all(32'h0000_03FF, 32'h0000_0155, 32'hFFFF_FFFF);
    queue_directed();
    drain();

    write_all($urandom, $urandom, $urandom);
    queue_random_traffic(30);
    drain();

    gap_pct   = 66;
    stall_pct = 8;
    write_all(32'h0, 32'h0, 32'h0);
    queue_random_traffic(30);
    drain();

    gap_pct   = 0;
    stall_pct = 0;
    write_all(32'hFFFF_FC00 | $urandom_range(0, 1023), 32'h0000_03FF, $urandom);
    queue_packet(255, 255);
    queue_random_traffic(30);
    drain();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/anc_frm_pkg.sv
rtl/anc_frm_pack.sv
rtl/anc_rtp_packet_framer_core.sv
bench/anc_rtp_packet_framer_core_tb.sv
